/* src/noq_pkg.sv */
// Shared types and constants for the normal octant quantizer.
// No dependencies; imported by noq_intake, noq_cell, the top level and the testbench.
package noq_pkg;

    localparam int NOQ_MAX_LEVEL      = 9;
    localparam int NOQ_COMPONENT_BITS = 16;

    // Level register width is fixed by the register map
    localparam int LEVEL_W = 4;
    localparam logic [LEVEL_W-1:0] LEVEL_RESET = 4'd9;

    typedef logic [1:0] sector_t;

    localparam sector_t SECTOR_X      = 2'd0;
    localparam sector_t SECTOR_Y      = 2'd1;
    localparam sector_t SECTOR_Z      = 2'd2;
    localparam sector_t SECTOR_CENTRE = 2'd3;

    // Per-item control travelling down the cell chain
    typedef struct packed {
        logic               valid;
        logic               flip;
        logic               zero;
        logic [LEVEL_W-1:0] level;
    } ctrl_t;

endpackage

/* src/noq_intake.sv */
// Input stage: sign split, magnitudes, component sum and initial box bounds.
// Depends on noq_pkg.
module noq_intake #(
    parameter int MAX_LEVEL      = 9,
    parameter int COMPONENT_BITS = 16
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          en,
    input  logic                                          in_valid,
    input  logic signed [COMPONENT_BITS-1:0]              comp_x,
    input  logic signed [COMPONENT_BITS-1:0]              comp_y,
    input  logic signed [COMPONENT_BITS-1:0]              comp_z,
    input  logic [noq_pkg::LEVEL_W-1:0]                   quant_level,
    output noq_pkg::ctrl_t                                out_ctrl,
    output logic [2:0][COMPONENT_BITS-1:0]                out_mag,
    output logic [2:0][COMPONENT_BITS+MAX_LEVEL:0]        out_lo,
    output logic [2:0][COMPONENT_BITS+MAX_LEVEL:0]        out_hi,
    output logic [2*MAX_LEVEL+2:0]                        out_code
);
    import noq_pkg::*;

    localparam int MW     = COMPONENT_BITS;
    localparam int SW     = COMPONENT_BITS + 1;
    localparam int HW     = COMPONENT_BITS + MAX_LEVEL + 1;
    localparam int CODE_W = 2 * MAX_LEVEL + 3;

    logic [2:0][MW-1:0] raw;
    logic [2:0][MW-1:0] mag;
    logic [2:0]         neg;
    logic [SW-1:0]      sum;
    logic [LEVEL_W-1:0] level_sat;
    ctrl_t              ctrl_next;

    ctrl_t                ctrl_reg;
    logic [2:0][MW-1:0]   mag_reg;
    logic [2:0][HW-1:0]   hi_reg;
    logic [CODE_W-1:0]    code_reg;

    assign raw[0] = unsigned'(comp_x);
    assign raw[1] = unsigned'(comp_y);
    assign raw[2] = unsigned'(comp_z);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            neg[i] = raw[i][MW-1];
            // most negative input wraps to 2^(MW-1), which still fits unsigned
            mag[i] = neg[i] ? (~raw[i] + 1'b1) : raw[i];
        end
    end

    assign sum = {1'b0, mag[0]} + {1'b0, mag[1]} + {1'b0, mag[2]};

    assign level_sat = (int'(quant_level) > MAX_LEVEL) ? LEVEL_W'(MAX_LEVEL) : quant_level;

    always_comb begin
        ctrl_next       = '0;
        ctrl_next.valid = in_valid;
        ctrl_next.zero  = (sum == '0);
        ctrl_next.level = level_sat;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg <= '0;
        end else if (en) begin
            ctrl_reg <= ctrl_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mag_reg  <= mag;
            // upper corner starts at 1.0, held pre-multiplied by the sum
            hi_reg   <= {3{sum, {MAX_LEVEL{1'b0}}}};
            code_reg <= {{(CODE_W-3){1'b0}}, neg[0], neg[1], neg[2]};
        end
    end

    assign out_ctrl = ctrl_reg;
    assign out_mag  = mag_reg;
    assign out_lo   = '0;
    assign out_hi   = hi_reg;
    assign out_code = code_reg;

endmodule

/* src/noq_cell.sv */
// One subdivision level: sector choice against the half box, box update.
// Depends on noq_pkg.
module noq_cell #(
    parameter int MAX_LEVEL      = 9,
    parameter int COMPONENT_BITS = 16,
    parameter int CELL_INDEX     = 0
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          en,
    input  noq_pkg::ctrl_t                                in_ctrl,
    input  logic [2:0][COMPONENT_BITS-1:0]                in_mag,
    input  logic [2:0][COMPONENT_BITS+MAX_LEVEL:0]        in_lo,
    input  logic [2:0][COMPONENT_BITS+MAX_LEVEL:0]        in_hi,
    input  logic [2*MAX_LEVEL+2:0]                        in_code,
    output noq_pkg::ctrl_t                                out_ctrl,
    output logic [2:0][COMPONENT_BITS-1:0]                out_mag,
    output logic [2:0][COMPONENT_BITS+MAX_LEVEL:0]        out_lo,
    output logic [2:0][COMPONENT_BITS+MAX_LEVEL:0]        out_hi,
    output logic [2*MAX_LEVEL+2:0]                        out_code
);
    import noq_pkg::*;

    localparam int MW     = COMPONENT_BITS;
    localparam int HW     = COMPONENT_BITS + MAX_LEVEL + 1;
    localparam int PW     = HW + 1;
    localparam int CODE_W = 2 * MAX_LEVEL + 3;

    // Bounds are kept as corner times sum, so lo+hi compares directly
    // against the magnitude scaled by 2^(MAX_LEVEL+1).
    logic [2:0][PW-1:0] pair;
    logic [2:0][PW-1:0] scaled;
    logic [2:0][HW-1:0] half;
    logic [2:0]         gt;
    logic [2:0]         lt;
    logic               active;
    sector_t            sector;

    ctrl_t              ctrl_next;
    logic [2:0][HW-1:0] lo_next;
    logic [2:0][HW-1:0] hi_next;
    logic [CODE_W-1:0]  code_next;

    ctrl_t              ctrl_reg;
    logic [2:0][MW-1:0] mag_reg;
    logic [2:0][HW-1:0] lo_reg;
    logic [2:0][HW-1:0] hi_reg;
    logic [CODE_W-1:0]  code_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            pair[i]   = {1'b0, in_lo[i]} + {1'b0, in_hi[i]};
            scaled[i] = {1'b0, in_mag[i], {(MAX_LEVEL+1){1'b0}}};
            gt[i]     = scaled[i] > pair[i];
            lt[i]     = scaled[i] < pair[i];
            // exact: lo+hi is even on every level that updates the box
            half[i]   = pair[i][PW-1:1];
        end
    end

    // ties fall through to the next axis
    always_comb begin
        sector = SECTOR_CENTRE;
        if (in_ctrl.flip) begin
            if (lt[2])      sector = SECTOR_Z;
            else if (lt[1]) sector = SECTOR_Y;
            else if (lt[0]) sector = SECTOR_X;
        end else begin
            if (gt[2])      sector = SECTOR_Z;
            else if (gt[1]) sector = SECTOR_Y;
            else if (gt[0]) sector = SECTOR_X;
        end
    end

    assign active = in_ctrl.valid && (int'(in_ctrl.level) > CELL_INDEX);

    always_comb begin
        ctrl_next = in_ctrl;
        lo_next   = in_lo;
        hi_next   = in_hi;
        code_next = in_code;
        if (active) begin
            if (in_ctrl.zero) begin
                code_next = {in_code[CODE_W-3:0], SECTOR_X};
            end else begin
                code_next = {in_code[CODE_W-3:0], sector};
                for (int j = 0; j < 3; j++) begin
                    if (in_ctrl.flip) begin
                        if (sector_t'(j) == sector) hi_next[j] = half[j];
                        else                        lo_next[j] = half[j];
                    end else begin
                        if (sector_t'(j) == sector) lo_next[j] = half[j];
                        else                        hi_next[j] = half[j];
                    end
                end
                if (sector == SECTOR_CENTRE) begin
                    ctrl_next.flip = !in_ctrl.flip;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg <= '0;
        end else if (en) begin
            ctrl_reg <= ctrl_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mag_reg  <= in_mag;
            lo_reg   <= lo_next;
            hi_reg   <= hi_next;
            code_reg <= code_next;
        end
    end

    assign out_ctrl = ctrl_reg;
    assign out_mag  = mag_reg;
    assign out_lo   = lo_reg;
    assign out_hi   = hi_reg;
    assign out_code = code_reg;

endmodule

/* src/noq_skid.sv */
// Output register with a one-item skid buffer; holds the chain while full.
// No package dependencies.
module noq_skid #(
    parameter int CODE_W = 21
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    input  logic [CODE_W-1:0] in_code,
    output logic              in_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [CODE_W-1:0] m_code
);
    logic              out_valid_reg;
    logic              skid_valid_reg;
    logic [CODE_W-1:0] out_code_reg;
    logic [CODE_W-1:0] skid_code_reg;
    logic              out_free;

    assign out_free = !out_valid_reg || m_ready;
    assign in_ready = !skid_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_ready) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (out_free) begin
            out_valid_reg <= in_valid;
        end else if (in_valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (m_ready) begin
                out_code_reg <= skid_code_reg;
            end
        end else if (out_free) begin
            out_code_reg <= in_code;
        end else begin
            skid_code_reg <= in_code;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_code  = out_code_reg;

endmodule

/* src/normal_octant_quantizer.sv */
// Hierarchical octahedral normal quantizer, top level.
// Depends on noq_pkg, noq_intake, noq_cell and noq_skid.
//
// Takes one vector per cycle and returns one code of 3+2*level bits per vector,
// in order. The accepting edge loads the intake stage, then the item passes
// through one cell per subdivision level (fixed chain of MAX_LEVEL cells,
// unused cells pass the item through), then the output register that drives
// m_valid. Throughput is one item per cycle, limited by the cell chain advancing
// one level per clock; the whole chain stalls only when the output register and
// its skid entry are both occupied. quant_level values above MAX_LEVEL act as
// MAX_LEVEL; the register is sampled as each item enters, and should be written
// only while the block is empty. cfg_ready is always high.
module normal_octant_quantizer #(
    parameter int MAX_LEVEL      = noq_pkg::NOQ_MAX_LEVEL,
    parameter int COMPONENT_BITS = noq_pkg::NOQ_COMPONENT_BITS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [noq_pkg::LEVEL_W-1:0]       cfg_quant_level,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [COMPONENT_BITS-1:0]  s_comp_x,
    input  logic signed [COMPONENT_BITS-1:0]  s_comp_y,
    input  logic signed [COMPONENT_BITS-1:0]  s_comp_z,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [2*MAX_LEVEL+2:0]            m_normal_code
);
    import noq_pkg::*;

    localparam int MW     = COMPONENT_BITS;
    localparam int HW     = COMPONENT_BITS + MAX_LEVEL + 1;
    localparam int CODE_W = 2 * MAX_LEVEL + 3;

    logic [LEVEL_W-1:0] quant_level_reg;
    logic               en;

    ctrl_t              st_ctrl [MAX_LEVEL+1];
    logic [2:0][MW-1:0] st_mag  [MAX_LEVEL+1];
    logic [2:0][HW-1:0] st_lo   [MAX_LEVEL+1];
    logic [2:0][HW-1:0] st_hi   [MAX_LEVEL+1];
    logic [CODE_W-1:0]  st_code [MAX_LEVEL+1];

    assign cfg_ready = 1'b1;
    assign s_ready   = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quant_level_reg <= LEVEL_RESET;
        end else if (cfg_valid && cfg_ready) begin
            quant_level_reg <= cfg_quant_level;
        end
    end

    noq_intake #(
        .MAX_LEVEL      (MAX_LEVEL),
        .COMPONENT_BITS (COMPONENT_BITS)
    ) u_intake (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .in_valid    (s_valid),
        .comp_x      (s_comp_x),
        .comp_y      (s_comp_y),
        .comp_z      (s_comp_z),
        .quant_level (quant_level_reg),
        .out_ctrl    (st_ctrl[0]),
        .out_mag     (st_mag[0]),
        .out_lo      (st_lo[0]),
        .out_hi      (st_hi[0]),
        .out_code    (st_code[0])
    );

    for (genvar k = 0; k < MAX_LEVEL; k++) begin : g_cell
        noq_cell #(
            .MAX_LEVEL      (MAX_LEVEL),
            .COMPONENT_BITS (COMPONENT_BITS),
            .CELL_INDEX     (k)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .in_ctrl  (st_ctrl[k]),
            .in_mag   (st_mag[k]),
            .in_lo    (st_lo[k]),
            .in_hi    (st_hi[k]),
            .in_code  (st_code[k]),
            .out_ctrl (st_ctrl[k+1]),
            .out_mag  (st_mag[k+1]),
            .out_lo   (st_lo[k+1]),
            .out_hi   (st_hi[k+1]),
            .out_code (st_code[k+1])
        );
    end

    noq_skid #(
        .CODE_W (CODE_W)
    ) u_skid (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (st_ctrl[MAX_LEVEL].valid),
        .in_code  (st_code[MAX_LEVEL]),
        .in_ready (en),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_code   (m_normal_code)
    );

endmodule

/* src/noq_checker.sv */
// Port-level checks for normal_octant_quantizer, attached by bind.
// Depends only on the top level's ports.
module noq_checker #(
    parameter int CODE_W = 21
) (
    input logic              aclk,
    input logic              aresetn,
    input logic              cfg_ready,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input logic [CODE_W-1:0] m_normal_code
);

    // a stalled result item holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_normal_code))
        else $error("result item changed while stalled");

    // nothing comes out straight after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // input back-pressure only while a result is waiting
    a_ready_low: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled with empty output");

    // skid fills only on a stalled output
    a_ready_fall: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_ready) |-> $past(m_valid && !m_ready))
        else $error("input stalled without output back-pressure");

    a_cfg_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_ready)
        else $error("configuration port not ready");

endmodule

bind normal_octant_quantizer noq_checker #(
    .CODE_W (CODE_W)
) u_noq_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .cfg_ready     (cfg_ready),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_normal_code (m_normal_code)
);

/* tb/normal_octant_quantizer_tb.sv */
// Self-checking testbench for normal_octant_quantizer: random and directed vectors
// across several quant_level settings, codes checked in order against a local model.
// Depends on noq_pkg and the normal_octant_quantizer RTL only.
module normal_octant_quantizer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import noq_pkg::*;

    localparam int COMP_W      = NOQ_COMPONENT_BITS;
    localparam int CODE_W      = 2 * NOQ_MAX_LEVEL + 3;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 45;
    localparam int HOLD_CYCLES = 60;

    typedef struct {
        logic signed [COMP_W-1:0] x;
        logic signed [COMP_W-1:0] y;
        logic signed [COMP_W-1:0] z;
    } vector_t;

    logic                     aclk            = 1'b0;
    logic                     aresetn         = 1'b0;
    logic                     cfg_valid       = 1'b0;
    logic                     cfg_ready;
    logic [LEVEL_W-1:0]       cfg_quant_level = '0;
    logic                     s_valid         = 1'b0;
    logic                     s_ready;
    logic signed [COMP_W-1:0] s_comp_x        = '0;
    logic signed [COMP_W-1:0] s_comp_y        = '0;
    logic signed [COMP_W-1:0] s_comp_z        = '0;
    logic                     m_valid;
    logic                     m_ready         = 1'b0;
    logic [CODE_W-1:0]        m_normal_code;

    vector_t           pending_vectors[$];
    logic [CODE_W-1:0] expected_codes[$];
    vector_t           next_vector;
    logic [LEVEL_W-1:0] level_setting;
    logic [LEVEL_W-1:0] level_plan [PHASES];
    int  idle_pct      = 24;
    bit  hold_request  = 1'b0;
    int  hold_left     = 0;
    bit  s_taken       = 1'b0;
    int  vectors_queued   = 0;
    int  vectors_accepted = 0;
    int  codes_checked    = 0;
    int  input_stalls     = 0;
    int  error_count      = 0;

    normal_octant_quantizer i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_quant_level (cfg_quant_level),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_comp_x        (s_comp_x),
        .s_comp_y        (s_comp_y),
        .s_comp_z        (s_comp_z),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_normal_code   (m_normal_code)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Octant sign bits, then one sector per level from successive box halving
    function automatic logic [CODE_W-1:0] quantize_normal(input vector_t v,
                                                          input logic [LEVEL_W-1:0] lvl_reg);
        logic signed [COMP_W-1:0] comp [3];
        longint unsigned mag [3];
        longint unsigned lo [3];
        longint unsigned hi [3];
        longint unsigned mid [3];
        longint unsigned half2;
        longint unsigned scaled;
        longint unsigned keep;
        longint unsigned sum;
        logic [63:0] code;
        int  lvl;
        bit  flip;
        sector_t sect;
        comp[0] = v.x;
        comp[1] = v.y;
        comp[2] = v.z;
        code = '0;
        flip = 1'b0;
        keep = 0;
        lvl = (lvl_reg > NOQ_MAX_LEVEL) ? NOQ_MAX_LEVEL : int'(lvl_reg);
        for (int i = 0; i < 3; i++) begin
            if (comp[i] < 0) begin
                code[2-i] = 1'b1;
                mag[i] = -longint'(comp[i]);
            end else begin
                mag[i] = longint'(comp[i]);
            end
        end
        sum = mag[0] + mag[1] + mag[2];
        if (lvl == 0 || sum == 0) begin
            code = code << (2 * lvl);
            return code[CODE_W-1:0];
        end
        for (int i = 0; i < 3; i++) begin
            lo[i] = 0;
            hi[i] = longint'(1) << NOQ_MAX_LEVEL;
        end
        while (lvl > 0) begin
            code = code << 2;
            lvl--;
            sect = SECTOR_CENTRE;
            // z first, then y, then x; a tie never wins
            for (int i = 2; i >= 0; i--) begin
                half2  = (lo[i] + hi[i]) * sum;
                scaled = mag[i] << (NOQ_MAX_LEVEL + 1);
                if (sect == SECTOR_CENTRE && (flip ? scaled < half2 : scaled > half2))
                    sect = sector_t'(i);
            end
            code[1:0] = sect;
            if (lvl > 0) begin
                for (int i = 0; i < 3; i++)
                    mid[i] = (lo[i] + hi[i]) >> 1;
                if (flip) begin
                    if (sect != SECTOR_CENTRE)
                        keep = lo[sect];
                    for (int i = 0; i < 3; i++)
                        lo[i] = mid[i];
                    if (sect != SECTOR_CENTRE) begin
                        hi[sect] = mid[sect];
                        lo[sect] = keep;
                    end else begin
                        flip = 1'b0;
                    end
                end else begin
                    if (sect != SECTOR_CENTRE)
                        keep = hi[sect];
                    for (int i = 0; i < 3; i++)
                        hi[i] = mid[i];
                    if (sect != SECTOR_CENTRE) begin
                        lo[sect] = mid[sect];
                        hi[sect] = keep;
                    end else begin
                        flip = 1'b1;
                    end
                end
            end
        end
        return code[CODE_W-1:0];
    endfunction

    // Mix of full-range, tiny (tie-prone), sparse, extreme, zero and scaled vectors
    function automatic vector_t random_vector();
        logic signed [COMP_W-1:0] c [3];
        vector_t v;
        int kind;
        int scale;
        kind  = $urandom_range(99);
        scale = $urandom_range(4000, 1);
        for (int i = 0; i < 3; i++) begin
            if (kind < 40) begin
                c[i] = COMP_W'($urandom_range(65535));
            end else if (kind < 60) begin
                c[i] = COMP_W'(int'($urandom_range(8)) - 4);
            end else if (kind < 70) begin
                c[i] = ($urandom_range(2) == 0) ? '0 : COMP_W'($urandom_range(65535));
            end else if (kind < 80) begin
                case ($urandom_range(4))
                    0:       c[i] = 16'sh8000;
                    1:       c[i] = 16'sh7fff;
                    2:       c[i] = '0;
                    3:       c[i] = -16'sd1;
                    default: c[i] = 16'sd1;
                endcase
            end else if (kind < 84) begin
                c[i] = '0;
            end else begin
                c[i] = COMP_W'((int'($urandom_range(16)) - 8) * scale);
            end
        end
        v.x = c[0];
        v.y = c[1];
        v.z = c[2];
        return v;
    endfunction

    task automatic queue_vector(input int x, input int y, input int z);
        vector_t v;
        v.x = COMP_W'(x);
        v.y = COMP_W'(y);
        v.z = COMP_W'(z);
        pending_vectors.push_back(v);
        vectors_queued++;
    endtask

    task automatic report_mismatch(input string what, input logic [CODE_W-1:0] got,
                                   input logic [CODE_W-1:0] want);
        $display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $time);
        error_count++;
    endtask

    task automatic wait_drained();
        while (vectors_accepted != vectors_queued || expected_codes.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_level(input logic [LEVEL_W-1:0] lvl);
        @(negedge aclk);
        cfg_valid       <= 1'b1;
        cfg_quant_level <= lvl;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        level_setting = lvl;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Sender
    always @(negedge aclk) begin
        if (aresetn && (!s_valid || s_taken)) begin
            s_taken = 1'b0;
            if (pending_vectors.size() != 0 && $urandom_range(99) >= idle_pct) begin
                next_vector = pending_vectors.pop_front();
                s_valid  <= 1'b1;
                s_comp_x <= next_vector.x;
                s_comp_y <= next_vector.y;
                s_comp_z <= next_vector.z;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && s_valid) begin
            if (s_ready) begin
                next_vector.x = s_comp_x;
                next_vector.y = s_comp_y;
                next_vector.z = s_comp_z;
                expected_codes.push_back(quantize_normal(next_vector, level_setting));
                vectors_accepted++;
                s_taken = 1'b1;
            end else begin
                input_stalls++;
            end
        end
    end

    // Receiver, with an occasional long hold-off so the pipe backs up
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_codes.size() == 0) begin
                report_mismatch("unexpected code", m_normal_code, '0);
            end else begin
                if (m_normal_code !== expected_codes[0])
                    report_mismatch("normal_code", m_normal_code, expected_codes[0]);
                void'(expected_codes.pop_front());
                codes_checked++;
            end
        end
    end

    initial begin
        level_plan = '{4'd0, 4'd15, 4'd1, 4'd2, 4'd9, 4'd12, 4'd5, 4'd3, 4'd10, 4'd9};
        level_setting = LEVEL_RESET;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed set at the reset level: extremes, axes, ties, centre
        queue_vector(0, 0, 0);
        queue_vector(32767, 32767, 32767);
        queue_vector(-32768, -32768, -32768);
        queue_vector(-32768, 0, 0);
        queue_vector(0, -32768, 0);
        queue_vector(0, 0, -32768);
        queue_vector(1, 0, 0);
        queue_vector(0, 1, 0);
        queue_vector(0, 0, 1);
        queue_vector(-1, 0, 0);
        queue_vector(0, -1, 0);
        queue_vector(0, 0, -1);
        queue_vector(1, 1, 0);
        queue_vector(1, 0, 1);
        queue_vector(0, 1, 1);
        queue_vector(1, 1, 1);
        queue_vector(-1, -1, -1);
        queue_vector(1, 2, 1);
        queue_vector(32767, -32768, 1);
        queue_vector(-32768, 32767, -1);
        queue_vector(3, 1, 0);
        queue_vector(1, 3, 0);
        queue_vector(5, -3, 7);
        queue_vector(100, -200, 300);
        wait_drained();

        for (int p = 0; p < PHASES; p++) begin
            write_level(level_plan[p]);
            idle_pct = (p == PHASES - 1) ? 0 : 24;
            if (p == 4) begin
                @(posedge aclk);
                hold_request = 1'b1;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pending_vectors.push_back(random_vector());
                vectors_queued++;
            end
            wait_drained();
        end

        repeat (NOQ_MAX_LEVEL + 6) @(posedge aclk);
        $display("Covered %0d vectors over %0d level settings (0 to 15, saturating above %0d);",
                 vectors_accepted, PHASES + 1, NOQ_MAX_LEVEL);
        $display("%0d codes checked, %0d input stall cycles under back-pressure.",
                 codes_checked, input_stalls);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #200000;
        $display("Timed out with %0d codes outstanding", expected_codes.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule
